@@ hdl/char_lcd_nibble_framer_macros.svh @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_framer_macros.svh
// Assertion macros shared by the checker of the display framer.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_FRAMER_MACROS_SVH
`define CHAR_LCD_NIBBLE_FRAMER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CLNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CLNF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/clnf_pkg.sv @@
// ----------------------------------------------------------------------------
// clnf_pkg
// Types, constants and helper functions of the character display framer.
// ----------------------------------------------------------------------------
package clnf_pkg;

  localparam int unsigned ColumnsW = 6;
  localparam int unsigned RowsW    = 3;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  localparam logic [ColumnsW-1:0] ColumnsReset = 6'd20;
  localparam logic [RowsW-1:0]    RowsReset    = 3'd4;
  localparam logic [RowsW-1:0]    RowsMax      = 3'd4;

  localparam logic [7:0] DdramSet = 8'h80;

  // Request codes; the fourth code is not used and is dropped.
  localparam logic [1:0] CmdChar   = 2'd0;
  localparam logic [1:0] CmdRaw    = 2'd1;
  localparam logic [1:0] CmdCursor = 2'd2;

  // Configuration register indexes.
  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;

  // One or two bytes to be sent for an accepted request.
  typedef struct packed {
    logic [7:0] byte0;
    logic       rs0;
    logic       two;
    logic [7:0] byte1;
  } desc_t;

  // DDRAM start address of each display row.
  function automatic logic [6:0] row_base_f(input logic [1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      2'd3:    base = 7'h54;
      default: base = 7'h00;
    endcase
    return base;
  endfunction

  // Shift register word: nibble in 7:4, enable in 3, RS in 1.
  function automatic logic [7:0] frame_f(input logic [7:0] data, input logic rs,
                                         input logic [1:0] step);
    logic [3:0] nib;
    nib = step[1] ? data[3:0] : data[7:4];
    return {nib, ~step[0], 1'b0, rs, 1'b0};
  endfunction

endpackage

@@ hdl/clnf_cursor.sv @@
// ----------------------------------------------------------------------------
// clnf_cursor
// Request decode, cursor tracking and configuration; registers one
// descriptor of the bytes to send per request, none for the unused code.
// ----------------------------------------------------------------------------
module clnf_cursor import clnf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          value_i,
  input  logic [6:0]          col_i,
  input  logic [1:0]          row_i,
  output logic                desc_valid_o,
  input  logic                desc_ready_i,
  output desc_t               desc_o
);

  logic [ColumnsW-1:0] columns_q;
  logic [RowsW-1:0]    rows_q;
  logic [6:0]          cursor_col_q, cursor_col_d;
  logic [1:0]          cursor_row_q, cursor_row_d;
  logic                desc_valid_q, desc_valid_d;
  desc_t               desc_q, desc_d;

  logic [RowsW-1:0] eff_rows;
  logic [1:0]       last_row;
  logic [7:0]       col_next;
  logic [RowsW-1:0] row_next;
  logic [1:0]       wrap_row;
  logic [1:0]       set_row;
  logic [6:0]       set_addr;
  logic             accept;

  assign accept      = req_valid_i & req_ready_o;
  assign req_ready_o = ~desc_valid_q | desc_ready_i;

  always_comb begin
    if (rows_q == '0) begin
      eff_rows = RowsW'(1);
    end else if (rows_q > RowsMax) begin
      eff_rows = RowsMax;
    end else begin
      eff_rows = rows_q;
    end
    last_row = 2'(eff_rows - RowsW'(1));
    col_next = {1'b0, cursor_col_q} + 8'd1;
    row_next = {1'b0, cursor_row_q} + RowsW'(1);
    wrap_row = (row_next >= eff_rows) ? 2'd0 : row_next[1:0];
    set_row  = ({1'b0, row_i} >= eff_rows) ? last_row : row_i;
    set_addr = col_i + row_base_f(set_row);
  end

  always_comb begin
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    desc_d       = desc_q;
    desc_valid_d = desc_valid_q & ~desc_ready_i;
    if (accept) begin
      desc_valid_d = 1'b1;
      desc_d.byte0 = value_i;
      desc_d.rs0   = 1'b0;
      desc_d.two   = 1'b0;
      desc_d.byte1 = DdramSet | {1'b0, row_base_f(wrap_row)};
      case (cmd_i)
        CmdChar: begin
          desc_d.rs0 = 1'b1;
          if (col_next >= {2'b00, columns_q}) begin
            desc_d.two   = 1'b1;
            cursor_col_d = '0;
            cursor_row_d = wrap_row;
          end else begin
            cursor_col_d = col_next[6:0];
          end
        end
        CmdRaw: begin
        end
        CmdCursor: begin
          desc_d.byte0 = DdramSet | {1'b0, set_addr};
          cursor_col_d = col_i;
          cursor_row_d = set_row;
        end
        default: begin
          desc_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= ColumnsReset;
      rows_q       <= RowsReset;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      desc_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgColumns) begin
        columns_q <= cfg_data_i[ColumnsW-1:0];
      end
      if (cfg_we_i && cfg_index_i == CfgRows) begin
        rows_q <= cfg_data_i[RowsW-1:0];
      end
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      desc_valid_q <= desc_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

endmodule

@@ hdl/clnf_serializer.sv @@
// ----------------------------------------------------------------------------
// clnf_serializer
// Turns a descriptor into four or eight frames, one per output word.
// ----------------------------------------------------------------------------
module clnf_serializer import clnf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       desc_valid_i,
  output logic       desc_ready_o,
  input  desc_t      desc_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_o,
  output logic       last_o
);

  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  desc_t      desc_q, desc_d;
  logic [7:0] frame_q, frame_d;
  logic       last_q, last_d;
  logic [2:0] idx_inc;
  logic       load;
  logic       advance;

  assign desc_ready_o = ~busy_q | (out_ready_i & last_q);
  assign load         = desc_valid_i & desc_ready_o;
  assign advance      = busy_q & out_ready_i & ~last_q;
  assign idx_inc      = idx_q + 3'd1;

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    desc_d  = desc_q;
    frame_d = frame_q;
    last_d  = last_q;
    if (load) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      desc_d  = desc_i;
      frame_d = frame_f(desc_i.byte0, desc_i.rs0, 2'd0);
      last_d  = 1'b0;
    end else if (advance) begin
      idx_d   = idx_inc;
      frame_d = idx_inc[2] ? frame_f(desc_q.byte1, 1'b0, idx_inc[1:0])
                           : frame_f(desc_q.byte0, desc_q.rs0, idx_inc[1:0]);
      last_d  = (idx_inc[1:0] == 2'd3) & (idx_inc[2] | ~desc_q.two);
    end else if (busy_q && out_ready_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q  <= desc_d;
    frame_q <= frame_d;
  end

  assign out_valid_o = busy_q;
  assign frame_o     = frame_q;
  assign last_o      = last_q;

endmodule

@@ hdl/char_lcd_nibble_framer.sv @@
// A request's first frame passes the descriptor register of the first stage
// and the frame register of the second stage before it is offered.
// A write emits four or eight frames, one per cycle while the frame side is
// ready; the frame counter of the serializer steps through them.
// A request code with no meaning is accepted and emits nothing.
// Reset (rst_ni, asynchronous, active low) puts the cursor at column 0, row 0,
// columns at 20 and rows at 4, and empties both stages.
// ----------------------------------------------------------------------------
// char_lcd_nibble_framer
// Frames character writes, command bytes and cursor moves for a character
// display in 4-bit mode that is driven through an 8-bit shift register.
// ----------------------------------------------------------------------------
module char_lcd_nibble_framer import clnf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes: index 0 is columns, index 1 is rows.
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request words.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // From bit 0: cmd[1:0], value[9:2], col[16:10], row[18:17], zeros above.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Frame words.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // From bit 0: frame[7:0].
  output logic [OutDataW-1:0] m_axis_tdata,
  // Set on the final frame caused by a request.
  output logic                m_axis_tlast
);

  logic  desc_valid;
  logic  desc_ready;
  desc_t desc;

  // The first stage decodes a request in the cycle it is accepted and updates
  // the tracked cursor at once, so the next request already sees the new
  // position. It holds the bytes to send in a descriptor register.
  clnf_cursor u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .cmd_i        (s_axis_tdata[1:0]),
    .value_i      (s_axis_tdata[9:2]),
    .col_i        (s_axis_tdata[16:10]),
    .row_i        (s_axis_tdata[18:17]),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready),
    .desc_o       (desc)
  );

  // The second stage walks through the frames of the descriptor: for each
  // byte, the high nibble with enable set and cleared, then the low nibble.
  // It takes the next descriptor while its final frame is being taken.
  clnf_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .desc_i       (desc),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .frame_o      (m_axis_tdata),
    .last_o       (m_axis_tlast)
  );

endmodule

@@ hdl/clnf_checker.sv @@
// ----------------------------------------------------------------------------
// clnf_checker
// Port level checks of the display framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_framer_macros.svh"

module clnf_checker import clnf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // A stalled frame word holds.
  `CLNF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "frame word changed while stalled")

  // Bits 2 and 0 of a frame are always clear.
  `CLNF_ASSERT(a_frame_zero_bits, m_axis_tvalid |-> !m_axis_tdata[2] && !m_axis_tdata[0], "unused frame bit set")

  // A request always ends on a frame with enable cleared.
  `CLNF_ASSERT(a_last_enable_low, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[3], "final frame has enable set")

  // A frame with enable set is always followed by the same nibble with enable cleared.
  `CLNF_ASSERT(a_enable_pair, m_axis_tvalid && m_axis_tready && m_axis_tdata[3] |=> m_axis_tvalid && !m_axis_tdata[3] && m_axis_tdata[7:4] == $past(m_axis_tdata[7:4]), "enable pulse not closed")

  // No frame is offered during reset.
  `CLNF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "frame offered in reset")

endmodule

bind char_lcd_nibble_framer clnf_checker u_clnf_checker (.*);

@@ tb/char_lcd_nibble_framer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_framer_checker
// Watches the configuration port and both word channels of the display
// framer. It tracks the cursor and settings itself, predicts the frame words
// of each accepted request, and compares them in order with the output words.
// ----------------------------------------------------------------------------
module char_lcd_nibble_framer_checker import clnf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // From bit 0: cmd[1:0], value[9:2], col[16:10], row[18:17], zeros above.
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // From bit 0: frame[7:0].
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  output int unsigned         errors_o,
  output int unsigned         pending_o,
  output int unsigned         requests_o,
  output int unsigned         frames_o
);

  typedef struct packed {
    logic [7:0] frame;
    logic       last;
  } frame_word_t;

  // DDRAM start addresses of rows 0 to 3, row 0 in the lowest bits.
  localparam logic [27:0] RowOffsets = {7'h54, 7'h14, 7'h40, 7'h00};

  frame_word_t         frames_due[$];
  logic [ColumnsW-1:0] columns_q;
  logic [RowsW-1:0]    rows_q;
  logic [6:0]          cursor_col;
  logic [1:0]          cursor_row;

  initial begin
    errors_o   = 0;
    requests_o = 0;
    frames_o   = 0;
  end

  task automatic log_frame_error(input string what, input logic [7:0] got_frame,
                                 input logic got_last, input frame_word_t want);
    $display("%0t ERROR: %s: got frame %02h last %0b, expected frame %02h last %0b",
             $realtime, what, got_frame, got_last, want.frame, want.last);
    errors_o++;
  endtask

  // The rows setting is clamped into 1..4 before use.
  function automatic int unsigned rows_in_use();
    if (rows_q == 0) return 1;
    if (rows_q > RowsMax) return 32'(RowsMax);
    return 32'(rows_q);
  endfunction

  // One byte goes out as high nibble then low nibble, each strobed with enable.
  task automatic queue_byte(input logic [7:0] data, input logic rs);
    frames_due.push_back({data[7:4], 1'b1, 1'b0, rs, 1'b0, 1'b0});
    frames_due.push_back({data[7:4], 1'b0, 1'b0, rs, 1'b0, 1'b0});
    frames_due.push_back({data[3:0], 1'b1, 1'b0, rs, 1'b0, 1'b0});
    frames_due.push_back({data[3:0], 1'b0, 1'b0, rs, 1'b0, 1'b0});
  endtask

  task automatic move_cursor(input logic [6:0] col, input logic [2:0] row);
    int unsigned lim;
    logic [6:0]  addr;
    lim = rows_in_use();
    if (row >= lim) row = 3'(lim - 1);
    cursor_col = col;
    cursor_row = row[1:0];
    addr = col + RowOffsets[cursor_row*7 +: 7];
    queue_byte(DdramSet | {1'b0, addr}, 1'b0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t want;
    logic [1:0]  cmd;
    logic [7:0]  value;
    logic [6:0]  col;
    logic [1:0]  row;
    logic [7:0]  next_col;
    logic [2:0]  next_row;
    if (!rst_ni) begin
      frames_due.delete();
      columns_q  = ColumnsReset;
      rows_q     = RowsReset;
      cursor_col = '0;
      cursor_row = '0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgColumns: columns_q = cfg_data_i[ColumnsW-1:0];
          CfgRows:    rows_q    = cfg_data_i[RowsW-1:0];
          default:    ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        frames_o++;
        if (frames_due.size() == 0) begin
          log_frame_error("frame word with nothing expected", m_axis_tdata, m_axis_tlast,
                          '0);
        end else begin
          want = frames_due.pop_front();
          if (m_axis_tdata !== want.frame)
            log_frame_error("frame mismatch", m_axis_tdata, m_axis_tlast, want);
          if (m_axis_tlast !== want.last)
            log_frame_error("last flag mismatch", m_axis_tdata, m_axis_tlast, want);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        requests_o++;
        cmd   = s_axis_tdata[1:0];
        value = s_axis_tdata[9:2];
        col   = s_axis_tdata[16:10];
        row   = s_axis_tdata[18:17];
        case (cmd)
          CmdChar: begin
            queue_byte(value, 1'b1);
            // The column advance is compared at 8 bits so column 127 still wraps.
            next_col = {1'b0, cursor_col} + 8'd1;
            if (next_col >= {2'b00, columns_q}) begin
              next_row = {1'b0, cursor_row} + 3'd1;
              if (next_row >= rows_in_use()) next_row = '0;
              move_cursor(7'd0, next_row);
            end else begin
              cursor_col = next_col[6:0];
            end
          end
          CmdRaw:    queue_byte(value, 1'b0);
          CmdCursor: move_cursor(col, {1'b0, row});
          default:   ;
        endcase
        if (cmd == CmdChar || cmd == CmdRaw || cmd == CmdCursor) begin
          want = frames_due.pop_back();
          want.last = 1'b1;
          frames_due.push_back(want);
        end
      end

      pending_o <= frames_due.size();
    end
  end

endmodule

@@ tb/tb_char_lcd_nibble_framer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_framer
// Drives character writes, command bytes, cursor moves and unused request
// codes into the display framer under several column and row settings, with
// random idle gaps on the request side and random stalls on the frame side.
// A checker beside the block predicts and compares every frame word.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_framer import clnf_pkg::*;;

  // The fourth request code has no meaning; the block drops it silently.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int unsigned ResetCycles = 11;
  // Cycles allowed after the last expected word before the block counts as idle.
  // A request passes only the descriptor and frame registers, so this is ample.
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PerPhase = 33;
  // Worst case is roughly 235 requests x 8 words, each behind the longest stall,
  // plus gaps, about 650 us; the limit is several times that.
  localparam int unsigned TimeoutNs = 5_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_last;

  int unsigned errors;
  int unsigned pending;
  int unsigned requests;
  int unsigned frames;
  int unsigned settings_seen = 1;
  // Cleared for whole phases so that some stretches run back to back.
  bit          idle_on = 1'b0;

  char_lcd_nibble_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  char_lcd_nibble_framer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .errors_o      (errors),
    .pending_o     (pending),
    .requests_o    (requests),
    .frames_o      (frames)
  );

  always #5 clk_i = ~clk_i;

  // Frame side: mostly ready, with short and occasional long stalls, and
  // now and then a calm stretch with no stall at all.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    logic        rdy;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        rdy = 1'b0;
        stall_left--;
      end else begin
        rdy = 1'b1;
        if (calm_left != 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(50, 200);
          else if (r < 30) stall_left = $urandom_range(1, 3);
          else if (r < 34) stall_left = $urandom_range(8, 30);
        end
      end
      m_ready <= rdy;
    end
  end

  // Gap before the next request word: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one request word and returns at the edge where it is taken.
  // Called right after a rising edge; valid is raised again in the same step
  // when no gap follows, so it never gets two assignments in one step.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] value,
                              input logic [6:0] col, input logic [1:0] row);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {5'b0, row, col, value, cmd};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // Waits until every predicted word has come out, then lets the block settle
  // in case an ignored request is still passing through.
  task automatic wait_for_frames();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both registers are written back to back once the block is idle.
  task automatic set_display(input logic [ColumnsW-1:0] ncols,
                             input logic [RowsW-1:0] nrows);
    wait_for_frames();
    cfg_we    <= 1'b1;
    cfg_index <= CfgColumns;
    cfg_data  <= CfgDataW'(ncols);
    @(posedge clk_i);
    cfg_index <= CfgRows;
    cfg_data  <= CfgDataW'(nrows);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // One random request. Cursor columns mostly stay near the display width so
  // that following characters reach the wrap, but the full range shows up too.
  task automatic random_request(input int unsigned ncols, output bit counted);
    int unsigned r;
    int unsigned col_top;
    logic [1:0]  cmd;
    logic [6:0]  col;
    r = $urandom_range(0, 99);
    if (r < 55) cmd = CmdChar;
    else if (r < 70) cmd = CmdRaw;
    else if (r < 95) cmd = CmdCursor;
    else cmd = CmdUnused;
    col_top = (ncols < 127) ? ncols : 127;
    if ($urandom_range(0, 9) < 7) col = 7'($urandom_range(0, col_top));
    else col = 7'($urandom_range(0, 127));
    send_request(cmd, 8'($urandom_range(0, 255)), col, 2'($urandom_range(0, 3)));
    counted = (cmd != CmdUnused);
  endtask

  initial begin
    int unsigned             counted_items;
    bit                      counted;
    logic [ColumnsW-1:0]     ncols;
    logic [RowsW-1:0]        nrows;
    rst_ni <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_for_frames();

    // Directed part at the reset setting of 20 columns and 4 rows. Character
    // and command bytes at both extremes, then a cursor move whose address
    // overflows 7 bits, and an unused code with every field bit set.
    send_request(CmdChar, 8'h00, 7'd0, 2'd0);
    send_request(CmdChar, 8'hFF, 7'd0, 2'd0);
    send_request(CmdRaw, 8'h00, 7'd0, 2'd0);
    send_request(CmdRaw, 8'hFF, 7'd0, 2'd0);
    send_request(CmdCursor, 8'h00, 7'd0, 2'd0);
    send_request(CmdCursor, 8'h00, 7'd127, 2'd3);
    send_request(CmdUnused, 8'hFF, 7'd127, 2'd3);
    // A character in the last column of the last row wraps to the top row,
    // and one on row 1 steps down to row 2; both add a cursor command.
    send_request(CmdCursor, 8'h00, 7'd19, 2'd3);
    send_request(CmdChar, 8'h5A, 7'd0, 2'd0);
    send_request(CmdCursor, 8'h00, 7'd19, 2'd1);
    send_request(CmdChar, 8'hA5, 7'd0, 2'd0);

    // Zero columns makes every character wrap; zero rows acts as one row, so
    // a cursor move to row 3 lands on row 0.
    set_display(6'd0, 3'd0);
    send_request(CmdChar, 8'h41, 7'd0, 2'd0);
    send_request(CmdChar, 8'h42, 7'd0, 2'd0);
    send_request(CmdCursor, 8'h00, 7'd5, 2'd3);

    // Widest column setting with a row count above four, and a cursor column
    // beyond the display that wraps on the next character.
    set_display(6'd63, 3'd7);
    send_request(CmdCursor, 8'h00, 7'd62, 2'd3);
    send_request(CmdChar, 8'h30, 7'd0, 2'd0);
    send_request(CmdChar, 8'h31, 7'd0, 2'd0);
    send_request(CmdCursor, 8'h00, 7'd100, 2'd2);
    send_request(CmdChar, 8'h32, 7'd0, 2'd0);

    // One column and two rows: characters alternate between the two rows.
    set_display(6'd1, 3'd2);
    send_request(CmdChar, 8'h7E, 7'd0, 2'd0);
    send_request(CmdChar, 8'h81, 7'd0, 2'd0);
    send_request(CmdCursor, 8'h00, 7'd3, 2'd2);
    send_request(CmdUnused, 8'h00, 7'd0, 2'd0);

    // Random part: one phase per display setting, extremes first.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin ncols = 6'd40; nrows = 3'd4; end
        1: begin ncols = 6'd1;  nrows = 3'd1; end
        2: begin ncols = 6'd63; nrows = 3'd5; end
        3: begin ncols = 6'd0;  nrows = 3'd0; end
        4: begin
          ncols = 6'($urandom_range(1, 40));
          nrows = 3'($urandom_range(1, 4));
        end
        default: begin
          ncols = 6'($urandom_range(0, 63));
          nrows = 3'($urandom_range(0, 7));
        end
      endcase
      set_display(ncols, nrows);
      idle_on = ($urandom_range(0, 3) != 0);
      counted_items = 0;
      while (counted_items < PerPhase) begin
        random_request(32'(ncols), counted);
        if (counted) counted_items++;
      end
    end

    wait_for_frames();
    $display("Covered %0d requests and %0d frame words over %0d display settings,",
             requests, frames, settings_seen);
    $display("including wrap cases, clamped rows and unused request codes.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog in case the block stops emitting words or stops taking requests.
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d frame words still expected.", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ char_lcd_nibble_framer.f @@
+incdir+hdl
hdl/clnf_pkg.sv
hdl/clnf_cursor.sv
hdl/clnf_serializer.sv
hdl/char_lcd_nibble_framer.sv
hdl/clnf_checker.sv
tb/char_lcd_nibble_framer_checker.sv
tb/tb_char_lcd_nibble_framer.sv
